// File: sv/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

    // Table and field geometry
    localparam int TABLE_DEPTH  = 256;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int MAX_CODE_LEN = 32;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int VALUE_W      = 16;
    localparam int ENTRY_W      = CODE_W + LEN_W + VALUE_W;

    // Bits gathered before the first table lookup, after reset
    localparam logic [LEN_W-1:0] FIRST_TRY_BITS = LEN_W'(8);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_DECODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_ENCODE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RES_SYMBOL   = 2'd0,
        RES_CODE     = 2'd1,
        RES_NO_CODE  = 2'd2,
        RES_NO_MATCH = 2'd3
    } res_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic load_out;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic res_emit;
        logic out_free;
    } ctl_stat_t;

endpackage

// File: sv/tpc_ram.sv
`timescale 1ns / 1ps

module tpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/tpc_ctrl.sv
`timescale 1ns / 1ps

module tpc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tpc_pkg::ctl_stat_t stat,
    output tpc_pkg::ctl_cmd_t  cmd
);

    import tpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stat.need_scan)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!stat.res_emit || stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall     = 1'b1;
        cmd.accept   = 1'b0;
        cmd.scan     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_RESULT:
            begin
                cmd.load_out = stat.res_emit && stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: sv/tpc_datapath.sv
`timescale 1ns / 1ps

module tpc_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tpc_pkg::LEN_W-1:0]        cfg_wr_data,
    input  logic [1:0]                       operation,
    input  logic [tpc_pkg::ADDR_W-1:0]       entry_index,
    input  logic [tpc_pkg::CODE_W-1:0]       entry_code,
    input  logic [tpc_pkg::LEN_W-1:0]        entry_length,
    input  logic signed [tpc_pkg::VALUE_W-1:0] symbol_value,
    input  logic                             data_bit,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic signed [tpc_pkg::VALUE_W-1:0] decoded_value,
    output logic [tpc_pkg::CODE_W-1:0]       code_bits,
    output logic [tpc_pkg::LEN_W-1:0]        code_length,
    input  tpc_pkg::ctl_cmd_t                cmd,
    output tpc_pkg::ctl_stat_t               stat
);

    import tpc_pkg::*;

    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_CODE_LEN);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

    op_t op_in;

    // Control state
    logic [LEN_W-1:0]       min_len_reg, min_len_next;
    logic [CODE_W-1:0]      buf_reg, buf_next;
    logic [LEN_W-1:0]       cnt_reg, cnt_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    op_t                    op_reg, op_next;
    logic [ADDR_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                   issue_reg, issue_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic                   rd_last_reg, rd_last_next;
    logic                   rd_ent_valid_reg, rd_ent_valid_next;
    logic                   res_emit_reg, res_emit_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload state
    logic [VALUE_W-1:0]     key_reg, key_next;
    res_status_t            res_status_reg, res_status_next;
    logic [VALUE_W-1:0]     res_value_reg, res_value_next;
    logic [CODE_W-1:0]      res_code_reg, res_code_next;
    logic [LEN_W-1:0]       res_len_reg, res_len_next;
    res_status_t            out_status_reg;
    logic [VALUE_W-1:0]     out_value_reg;
    logic [CODE_W-1:0]      out_code_reg;
    logic [LEN_W-1:0]       out_len_reg;

    // Table memory signals
    logic                   ram_wr_en;
    logic [ENTRY_W-1:0]     ram_wr_data;
    logic                   ram_rd_en;
    logic [ENTRY_W-1:0]     ram_rd_data;
    logic [CODE_W-1:0]      ent_code;
    logic [LEN_W-1:0]       ent_len;
    logic [VALUE_W-1:0]     ent_value;

    logic [LEN_W-1:0]       min_len_eff;
    logic [LEN_W-1:0]       cnt_inc;
    logic [CODE_W-1:0]      load_mask;
    logic                   load_ok;
    logic                   hit;
    logic                   scan_done;

    assign op_in = op_t'(operation);

    // Clamp the threshold to 1..MAX_CODE_LEN
    always_comb
    begin
        priority if (min_len_reg == '0)
        begin
            min_len_eff = LEN_W'(1);
        end
        else if (min_len_reg > MAX_LEN)
        begin
            min_len_eff = MAX_LEN;
        end
        else
        begin
            min_len_eff = min_len_reg;
        end
    end

    assign cnt_inc   = cnt_reg + LEN_W'(1);
    assign load_mask = ~({CODE_W{1'b1}} << entry_length);
    assign load_ok   = (entry_length != '0) && (entry_length <= MAX_LEN);

    // Table write on load items
    assign ram_wr_en   = cmd.accept && (op_in == OP_LOAD);
    assign ram_wr_data = {entry_code & load_mask, entry_length, symbol_value};

    assign ram_rd_en = cmd.scan && issue_reg;

    tpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (entry_index),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (ram_rd_data)
    );

    assign ent_code  = ram_rd_data[ENTRY_W-1 -: CODE_W];
    assign ent_len   = ram_rd_data[VALUE_W +: LEN_W];
    assign ent_value = ram_rd_data[VALUE_W-1:0];

    // Compare the entry read last cycle against the key of this item
    always_comb
    begin
        hit = 1'b0;
        if (rd_valid_reg && rd_ent_valid_reg)
        begin
            if (op_reg == OP_ENCODE)
            begin
                hit = (ent_value == key_reg);
            end
            else
            begin
                hit = (ent_len == cnt_reg) && (ent_code == buf_reg);
            end
        end
    end

    assign scan_done = rd_valid_reg && (hit || rd_last_reg);

    // Status toward the controller
    always_comb
    begin
        stat.scan_done = scan_done;
        stat.res_emit  = res_emit_reg;
        stat.out_free  = !out_valid_reg || !out_stall;
        unique case (op_in)
            OP_LOAD:   stat.need_scan = 1'b0;
            OP_DECODE: stat.need_scan = (cnt_inc >= min_len_eff);
            OP_FLUSH:  stat.need_scan = (cnt_reg != '0);
            OP_ENCODE: stat.need_scan = 1'b1;
            default:   stat.need_scan = 1'b0;
        endcase
    end

    // Next-state logic
    always_comb
    begin
        min_len_next      = min_len_reg;
        buf_next          = buf_reg;
        cnt_next          = cnt_reg;
        valid_next        = valid_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        scan_addr_next    = scan_addr_reg;
        issue_next        = issue_reg;
        rd_valid_next     = 1'b0;
        rd_last_next      = rd_last_reg;
        rd_ent_valid_next = rd_ent_valid_reg;
        res_emit_next     = res_emit_reg;
        res_status_next   = res_status_reg;
        res_value_next    = res_value_reg;
        res_code_next     = res_code_reg;
        res_len_next      = res_len_reg;
        out_valid_next    = out_valid_reg;

        if (cfg_wr_en)
        begin
            min_len_next = cfg_wr_data;
        end

        // Take an item: latch key, set a load's valid bit, shift a decode bit, arm the scan
        if (cmd.accept)
        begin
            op_next        = op_in;
            key_next       = symbol_value;
            scan_addr_next = '0;
            issue_next     = 1'b1;
            if (op_in == OP_LOAD)
            begin
                valid_next[entry_index] = load_ok;
            end
            if (op_in == OP_DECODE)
            begin
                buf_next = {buf_reg[CODE_W-2:0], data_bit};
                cnt_next = cnt_inc;
            end
        end

        // Walk the table, one entry per cycle
        if (cmd.scan && issue_reg && !scan_done)
        begin
            rd_valid_next     = 1'b1;
            rd_last_next      = (scan_addr_reg == LAST_ADDR);
            rd_ent_valid_next = valid_reg[scan_addr_reg];
            scan_addr_next    = scan_addr_reg + ADDR_W'(1);
            issue_next        = (scan_addr_reg != LAST_ADDR);
        end

        // Resolve the scan
        if (cmd.scan && scan_done)
        begin
            res_emit_next   = 1'b1;
            res_status_next = RES_NO_MATCH;
            res_value_next  = '0;
            res_code_next   = '0;
            res_len_next    = '0;
            unique case (op_reg)
                OP_ENCODE:
                begin
                    if (hit)
                    begin
                        res_status_next = RES_CODE;
                        res_code_next   = ent_code;
                        res_len_next    = ent_len;
                    end
                    else
                    begin
                        res_status_next = RES_NO_CODE;
                    end
                end
                OP_FLUSH:
                begin
                    buf_next = '0;
                    cnt_next = '0;
                    if (hit)
                    begin
                        res_status_next = RES_SYMBOL;
                        res_value_next  = ent_value;
                    end
                end
                default:
                begin
                    if (hit)
                    begin
                        res_status_next = RES_SYMBOL;
                        res_value_next  = ent_value;
                        buf_next        = '0;
                        cnt_next        = '0;
                    end
                    else if (cnt_reg >= MAX_LEN)
                    begin
                        buf_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        res_emit_next = 1'b0;
                    end
                end
            endcase
        end

        // Output register: drop a taken beat, load a new one
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg      <= FIRST_TRY_BITS;
            buf_reg          <= '0;
            cnt_reg          <= '0;
            valid_reg        <= '0;
            op_reg           <= OP_LOAD;
            scan_addr_reg    <= '0;
            issue_reg        <= 1'b0;
            rd_valid_reg     <= 1'b0;
            rd_last_reg      <= 1'b0;
            rd_ent_valid_reg <= 1'b0;
            res_emit_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            min_len_reg      <= min_len_next;
            buf_reg          <= buf_next;
            cnt_reg          <= cnt_next;
            valid_reg        <= valid_next;
            op_reg           <= op_next;
            scan_addr_reg    <= scan_addr_next;
            issue_reg        <= issue_next;
            rd_valid_reg     <= rd_valid_next;
            rd_last_reg      <= rd_last_next;
            rd_ent_valid_reg <= rd_ent_valid_next;
            res_emit_reg     <= res_emit_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_code_reg   <= res_code_next;
        res_len_reg    <= res_len_next;
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_code_reg   <= res_code_reg;
            out_len_reg    <= res_len_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign decoded_value = out_value_reg;
    assign code_bits     = out_code_reg;
    assign code_length   = out_len_reg;

endmodule

// File: sv/table_prefix_code_codec_core.sv
`timescale 1ns / 1ps

// Table-driven prefix-code codec. Load items fill a 256-entry code table
// (code, length, signed value), one slot per load item. A decode item shifts one
// bit into the buffer; once the buffer holds at least min_code_length bits
// (register, reset 8, clamped to 1..32) the table is scanned for a valid
// entry of the same length and code, the lowest matching slot winning. A
// match returns status 0 with the value and empties the buffer; 32 bits
// without a match return status 3. Flush resolves leftover bits at the end
// of a stream (status 0 or 3); an encode item searches by value and returns
// status 1 with code and length, or status 2. The scan reads one table entry
// per cycle through the single read port of the table memory and stops at
// the first match; the result of an item that scans, if it has one, passes
// through the result register into the output register, and only then is
// the next item taken. A load, or a decode bit below the threshold, is
// taken without a scan. One item is worked at a time; a finished result
// waits in the output register while the next item is taken, and a second
// result holds the input stalled until the first beat leaves. No clearing
// pass is needed after reset.
module table_prefix_code_codec_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [tpc_pkg::LEN_W-1:0]          cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [tpc_pkg::ADDR_W-1:0]         entry_index,
    input  logic [tpc_pkg::CODE_W-1:0]         entry_code,
    input  logic [tpc_pkg::LEN_W-1:0]          entry_length,
    input  logic signed [tpc_pkg::VALUE_W-1:0] symbol_value,
    input  logic                               data_bit,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic signed [tpc_pkg::VALUE_W-1:0] decoded_value,
    output logic [tpc_pkg::CODE_W-1:0]         code_bits,
    output logic [tpc_pkg::LEN_W-1:0]          code_length
);

    import tpc_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;

    tpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    tpc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .operation     (operation),
        .entry_index   (entry_index),
        .entry_code    (entry_code),
        .entry_length  (entry_length),
        .symbol_value  (symbol_value),
        .data_bit      (data_bit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .decoded_value (decoded_value),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

// File: tb/sv/table_prefix_code_codec_checker.sv
`timescale 1ns / 1ps

module table_prefix_code_codec_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [tpc_pkg::LEN_W-1:0]          cfg_wr_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [tpc_pkg::ADDR_W-1:0]         entry_index,
    input  logic [tpc_pkg::CODE_W-1:0]         entry_code,
    input  logic [tpc_pkg::LEN_W-1:0]          entry_length,
    input  logic signed [tpc_pkg::VALUE_W-1:0] symbol_value,
    input  logic                               data_bit,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [1:0]                         status,
    input  logic signed [tpc_pkg::VALUE_W-1:0] decoded_value,
    input  logic [tpc_pkg::CODE_W-1:0]         code_bits,
    input  logic [tpc_pkg::LEN_W-1:0]          code_length,
    output int                                 error_count,
    output int                                 results_owed
);

    import tpc_pkg::*;

    typedef struct packed {
        res_status_t        status;
        logic [VALUE_W-1:0] value;
        logic [CODE_W-1:0]  code;
        logic [LEN_W-1:0]   length;
    } codec_result_t;

    // Shadow copy of the code table, the bit buffer and the register
    logic                    slot_live  [TABLE_DEPTH];
    logic [CODE_W-1:0]       slot_code  [TABLE_DEPTH];
    logic [LEN_W-1:0]        slot_len   [TABLE_DEPTH];
    logic [VALUE_W-1:0]      slot_value [TABLE_DEPTH];
    logic [MAX_CODE_LEN-1:0] shift_reg;
    int                      shift_fill;
    logic [LEN_W-1:0]        min_len_cfg;

    codec_result_t owed_q [$];
    int            fail_tally;

    function automatic logic [63:0] low_ones(int n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Lowest live slot whose length and code equal the buffered bits
    function automatic int lookup_code(logic [MAX_CODE_LEN-1:0] bits, int count);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (slot_live[i] && int'(slot_len[i]) == count &&
                slot_code[i] == CODE_W'(64'(bits) & low_ones(count)))
                return i;
        return -1;
    endfunction

    // Update the shadow state for one accepted beat and queue any result it owes
    task automatic predict_item(op_t op, logic [ADDR_W-1:0] idx, logic [CODE_W-1:0] code,
                                logic [LEN_W-1:0] len, logic [VALUE_W-1:0] val,
                                logic coded_bit);
        int            hit;
        int            fill_floor;
        codec_result_t r;
        r = '0;
        hit = -1;
        case (op)
            OP_LOAD: begin
                slot_code[idx]  = CODE_W'(64'(code) & low_ones(len));
                slot_len[idx]   = len;
                slot_value[idx] = val;
                slot_live[idx]  = (len >= 1 && len <= MAX_CODE_LEN);
            end
            OP_ENCODE: begin
                for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                    if (slot_live[i] && slot_value[i] == val)
                        hit = i;
                if (hit >= 0) begin
                    r.status = RES_CODE;
                    r.code   = slot_code[hit];
                    r.length = slot_len[hit];
                end else
                    r.status = RES_NO_CODE;
                owed_q.push_back(r);
            end
            OP_FLUSH: begin
                // Resolve leftover bits regardless of the threshold
                if (shift_fill != 0) begin
                    hit = lookup_code(shift_reg, shift_fill);
                    shift_reg  = '0;
                    shift_fill = 0;
                    if (hit >= 0) begin
                        r.status = RES_SYMBOL;
                        r.value  = slot_value[hit];
                    end else
                        r.status = RES_NO_MATCH;
                    owed_q.push_back(r);
                end
            end
            OP_DECODE: begin
                fill_floor = (min_len_cfg == 0) ? 1 :
                             ((min_len_cfg > MAX_CODE_LEN) ? MAX_CODE_LEN : min_len_cfg);
                shift_reg  = {shift_reg[MAX_CODE_LEN-2:0], coded_bit};
                shift_fill = shift_fill + 1;
                if (shift_fill >= fill_floor)
                    hit = lookup_code(shift_reg, shift_fill);
                if (hit >= 0) begin
                    shift_reg  = '0;
                    shift_fill = 0;
                    r.status   = RES_SYMBOL;
                    r.value    = slot_value[hit];
                    owed_q.push_back(r);
                end else if (shift_fill >= MAX_CODE_LEN) begin
                    // Full buffer without a match: drop the bits
                    shift_reg  = '0;
                    shift_fill = 0;
                    r.status   = RES_NO_MATCH;
                    owed_q.push_back(r);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        codec_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_live[i]  = 1'b0;
                slot_code[i]  = '0;
                slot_len[i]   = '0;
                slot_value[i] = '0;
            end
            shift_reg    = '0;
            shift_fill   = 0;
            min_len_cfg  = FIRST_TRY_BITS;
            fail_tally   = 0;
            owed_q.delete();
            error_count  <= 0;
            results_owed <= 0;
        end else begin
            if (cfg_wr_en)
                min_len_cfg = cfg_wr_data;

            // Check the output beat first: it always belongs to an older input
            if (out_valid && !out_stall) begin
                if (owed_q.size() == 0) begin
                    if (fail_tally < 10)
                        $display("ERROR %0t: unexpected result status %0d value %0d code %h len %0d",
                                 $time, status, decoded_value, code_bits, code_length);
                    fail_tally++;
                end else begin
                    want = owed_q.pop_front();
                    if (want.status != status || want.value != decoded_value ||
                        want.code != code_bits || want.length != code_length) begin
                        if (fail_tally < 10) begin
                            $display("ERROR %0t: expected status %0d value %0d code %h len %0d",
                                     $time, want.status, $signed(want.value), want.code,
                                     want.length);
                            $display("ERROR %0t:   actual status %0d value %0d code %h len %0d",
                                     $time, status, decoded_value, code_bits, code_length);
                        end
                        fail_tally++;
                    end
                end
            end

            if (in_valid && !in_stall)
                predict_item(op_t'(operation), entry_index, entry_code, entry_length,
                             symbol_value, data_bit);

            error_count  <= fail_tally;
            results_owed <= owed_q.size();
        end
    end

endmodule

// File: tb/sv/tb_table_prefix_code_codec_core.sv
`timescale 1ns / 1ps

module tb_table_prefix_code_codec_core;

    import tpc_pkg::*;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [LEN_W-1:0]            cfg_wr_data;
    logic                        in_valid;
    logic                        in_stall;
    logic [1:0]                  operation;
    logic [ADDR_W-1:0]           entry_index;
    logic [CODE_W-1:0]           entry_code;
    logic [LEN_W-1:0]            entry_length;
    logic signed [VALUE_W-1:0]   symbol_value;
    logic                        data_bit;
    logic                        out_valid;
    logic                        out_stall;
    logic [1:0]                  status;
    logic signed [VALUE_W-1:0]   decoded_value;
    logic [CODE_W-1:0]           code_bits;
    logic [LEN_W-1:0]            code_length;

    int mismatch_total;
    int results_owed;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int items_sent      = 0;

    // Current prefix-free code set, loaded into consecutive slots
    logic [CODE_W-1:0]         set_code [8];
    int                        set_len  [8];
    logic signed [VALUE_W-1:0] set_val  [8];
    int                        set_n    = 0;

    table_prefix_code_codec_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .entry_index   (entry_index),
        .entry_code    (entry_code),
        .entry_length  (entry_length),
        .symbol_value  (symbol_value),
        .data_bit      (data_bit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .decoded_value (decoded_value),
        .code_bits     (code_bits),
        .code_length   (code_length)
    );

    table_prefix_code_codec_checker codec_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .entry_index   (entry_index),
        .entry_code    (entry_code),
        .entry_length  (entry_length),
        .symbol_value  (symbol_value),
        .data_bit      (data_bit),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .decoded_value (decoded_value),
        .code_bits     (code_bits),
        .code_length   (code_length),
        .error_count   (mismatch_total),
        .results_owed  (results_owed)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_cycles > 0) begin
                out_stall <= 1'b1;
                hold_off_cycles--;
            end else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one input beat after a random gap and hold it until accepted
    task automatic send_item(op_t op, logic [ADDR_W-1:0] idx, logic [CODE_W-1:0] code,
                             logic [LEN_W-1:0] len, logic signed [VALUE_W-1:0] val,
                             logic coded_bit);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        entry_index  <= idx;
        entry_code   <= code;
        entry_length <= len;
        symbol_value <= val;
        data_bit     <= coded_bit;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic push_load(logic [ADDR_W-1:0] idx, logic [CODE_W-1:0] code,
                             logic [LEN_W-1:0] len, logic signed [VALUE_W-1:0] val);
        send_item(OP_LOAD, idx, code, len, val, 1'($urandom));
    endtask

    task automatic push_bit(logic coded_bit);
        send_item(OP_DECODE, ADDR_W'($urandom), $urandom, LEN_W'($urandom),
                  VALUE_W'($urandom), coded_bit);
    endtask

    task automatic push_flush();
        send_item(OP_FLUSH, ADDR_W'($urandom), $urandom, LEN_W'($urandom),
                  VALUE_W'($urandom), 1'($urandom));
    endtask

    task automatic push_encode(logic signed [VALUE_W-1:0] val);
        send_item(OP_ENCODE, ADDR_W'($urandom), $urandom, LEN_W'($urandom), val,
                  1'($urandom));
    endtask

    // Send the leading nbits of a code from the set, first bit first
    task automatic push_code_bits(int k, int nbits);
        for (int b = set_len[k] - 1; b >= set_len[k] - nbits; b--)
            push_bit(set_code[k][b]);
    endtask

    // Drop valid, drain all owed results, then let any silent item finish
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
        repeat (300) @(posedge clk);
    endtask

    // Build a canonical prefix code sized for the threshold and load it
    task automatic build_code_set(int min_cfg);
        int               eff_min;
        int               want_n;
        int               k;
        int               j;
        int               tmp;
        int               lens [8];
        logic [63:0]      next_code;
        logic [CODE_W-1:0] flip;
        logic [CODE_W-1:0] hi_mask;
        logic [ADDR_W-1:0] slot;
        eff_min = (min_cfg < 1) ? 1 : ((min_cfg > MAX_CODE_LEN) ? MAX_CODE_LEN : min_cfg);
        want_n  = $urandom_range(8, 2);
        for (k = 0; k < want_n; k++) begin
            lens[k] = eff_min + $urandom_range(3);
            if (lens[k] > MAX_CODE_LEN)
                lens[k] = MAX_CODE_LEN;
            // Now and then a code shorter than the threshold: only a flush finds it
            if (eff_min > 1 && $urandom_range(9) == 0)
                lens[k] = $urandom_range(eff_min - 1, 1);
        end
        for (k = 1; k < want_n; k++)
            for (j = k; j > 0 && lens[j-1] > lens[j]; j--) begin
                tmp       = lens[j];
                lens[j]   = lens[j-1];
                lens[j-1] = tmp;
            end

        // XOR with one fixed bit string keeps the set prefix-free
        flip      = $urandom;
        next_code = '0;
        set_n     = 0;
        for (k = 0; k < want_n; k++) begin
            if (k > 0)
                next_code = (next_code + 64'd1) << (lens[k] - lens[k-1]);
            if ((next_code >> lens[k]) == 0) begin
                set_len[set_n]  = lens[k];
                set_code[set_n] = CODE_W'(next_code) ^ (flip >> (CODE_W - lens[k]));
                set_val[set_n]  = VALUE_W'($urandom);
                set_n++;
            end
        end

        // Junk above the code length must be dropped by the block
        slot = ADDR_W'($urandom);
        for (k = 0; k < set_n; k++) begin
            hi_mask = (set_len[k] >= CODE_W) ? '0 : ~((32'd1 << set_len[k]) - 32'd1);
            push_load(ADDR_W'(slot + k), set_code[k] | ($urandom & hi_mask),
                      LEN_W'(set_len[k]), set_val[k]);
        end
    endtask

    initial begin : stimulus
        int phase;
        int cfg_now;
        int phase_start;
        int pick;
        int reps;
        int k;
        rst_n        <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        in_valid     <= 1'b0;
        operation    <= OP_LOAD;
        entry_index  <= '0;
        entry_code   <= '0;
        entry_length <= '0;
        symbol_value <= '0;
        data_bit     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats at the reset threshold of eight bits
        push_load(8'd0, 32'h0000_00A5, 6'd8, 16'sh8000);
        push_load(8'd255, 32'hFFFF_FFFF, 6'd32, 16'sh7FFF);
        push_load(8'd1, 32'hFFFF_FFFF, 6'd1, 16'sd7);     // upper code bits dropped
        push_load(8'd2, 32'h0000_0005, 6'd0, 16'sd100);   // zero length stays invalid
        push_load(8'd3, 32'h0000_0006, 6'd40, 16'sd200);  // too long, invalid
        push_load(8'd4, 32'h0000_00A5, 6'd8, 16'sd5);     // same code as slot 0
        push_load(8'd5, 32'h0000_0005, 6'd3, 16'sh7FFF);  // same value as slot 255
        push_encode(16'sh8000);
        push_encode(16'sh7FFF);
        push_encode(16'sd100);
        push_encode(16'sd200);
        push_encode(16'sd12345);
        for (int i = 7; i >= 0; i--)
            push_bit(1'(8'hA5 >> i));
        push_flush();                                      // empty buffer: silent
        push_bit(1'b1);
        push_flush();                                      // short code via flush
        push_bit(1'b0);
        push_bit(1'b0);
        push_flush();                                      // leftover matches nothing

        for (phase = 0; phase < 8; phase++) begin
            settle();
            case (phase)
                0:       cfg_now = 1;
                1:       cfg_now = 0;
                2:       cfg_now = 32;
                3:       cfg_now = 63;
                4:       cfg_now = 4;
                5:       cfg_now = 8;
                6:       cfg_now = 13;
                default: cfg_now = $urandom_range(63, 1);
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= LEN_W'(cfg_now);
            @(posedge clk);
            cfg_wr_en <= 1'b0;

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            // Back up the output long enough to stall the input side
            if (phase == 0)
                hold_off_cycles = 2000;

            build_code_set(cfg_now);
            phase_start = items_sent;
            while (items_sent - phase_start < 200) begin
                pick = $urandom_range(99);
                if (pick < 6)
                    build_code_set(cfg_now);
                else if (pick < 56) begin
                    reps = $urandom_range(4, 1);
                    repeat (reps) begin
                        k = $urandom_range(set_n - 1);
                        push_code_bits(k, set_len[k]);
                    end
                end else if (pick < 66) begin
                    k = $urandom_range(set_n - 1);
                    push_code_bits(k, $urandom_range(set_len[k]));
                    push_flush();
                end else if (pick < 84) begin
                    if ($urandom_range(4) != 0)
                        push_encode(set_val[$urandom_range(set_n - 1)]);
                    else
                        push_encode(VALUE_W'($urandom));
                end else
                    send_item(op_t'($urandom_range(3)), ADDR_W'($urandom), $urandom,
                              LEN_W'($urandom), VALUE_W'($urandom), 1'($urandom));
            end
        end

        settle();
        if (mismatch_total == 0 && results_owed == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin : watchdog
        #25_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
sv/tpc_pkg.sv
sv/tpc_ram.sv
sv/tpc_ctrl.sv
sv/tpc_datapath.sv
sv/table_prefix_code_codec_core.sv
tb/sv/table_prefix_code_codec_checker.sv
tb/sv/tb_table_prefix_code_codec_core.sv
